// File: rtl/cpwv_pkg.sv
`default_nettype none

package cpwv_pkg;

  // Transaction status codes, in the encoding carried on the result stream.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_VALUE = 2'd1,
    ST_NOT_ARMED = 2'd2
  } status_t;

  // Page register indexes with a rule of their own.
  localparam logic [7:0] REG_ARM      = 8'd0;
  localparam logic [7:0] REG_THROTTLE = 8'd1;
  localparam logic [7:0] REG_POLES    = 8'd2;
  localparam logic [7:0] CLEAR_INDEX  = 8'd3;

  // Configuration register indexes (byte address 4 * index).
  localparam logic [1:0] CFG_THROTTLE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_POLES_LOWEST   = 2'd1;
  localparam logic [1:0] CFG_POLES_HIGHEST  = 2'd2;
  localparam logic [1:0] CFG_CLEAR_KEY      = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] THROTTLE_LIMIT_RST = 16'd1000;
  localparam logic [15:0] POLES_LOWEST_RST   = 16'd2;
  localparam logic [15:0] POLES_HIGHEST_RST  = 16'd36;
  localparam logic [15:0] CLEAR_KEY_RST      = 16'd42405;

  // One result item; the first member listed lands in the highest bits.
  typedef struct packed {
    logic [15:0] poles_now;
    logic [15:0] throttle_now;
    logic [15:0] arm_now;
    logic        cleared;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/control_page_write_validator.sv
// A transaction's result is registered into the output buffer as its last word is accepted.
// Throughput: one word per cycle while s_tready is high; checks are one pass of small compares.
// A two-entry output buffer lets words keep flowing while a result waits on m_tready.
// Reset (rst, synchronous, active high) clears the page, any open transaction, the output
// buffer, and restores the configuration registers to their reset values.
`default_nettype none

module control_page_write_validator import cpwv_pkg::*; #(
  parameter int MAX_WORDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // Word stream. s_tdata: start_offset [7:0], word_value [23:8].
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tlast,   // last_word
  input  wire logic        s_tuser,   // arm_allowed

  // Result stream. m_tdata: status [1:0], cleared [2], arm_now [18:3],
  // throttle_now [34:19], poles_now [50:35], zero fill [55:51].
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [55:0] m_tdata,

  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  // The position counter must be able to hold MAX_WORDS itself, where it saturates.
  localparam int PW = $clog2(MAX_WORDS + 1);
  localparam logic [PW-1:0] POS_FULL = PW'(MAX_WORDS);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [15:0] throttle_limit;
  logic [15:0] poles_lowest;
  logic [15:0] poles_highest;
  logic [15:0] clear_key;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_limit <= THROTTLE_LIMIT_RST;
      poles_lowest   <= POLES_LOWEST_RST;
      poles_highest  <= POLES_HIGHEST_RST;
      clear_key      <= CLEAR_KEY_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        CFG_THROTTLE_LIMIT: throttle_limit <= pwdata[15:0];
        CFG_POLES_LOWEST:   poles_lowest   <= pwdata[15:0];
        CFG_POLES_HIGHEST:  poles_highest  <= pwdata[15:0];
        CFG_CLEAR_KEY:      clear_key      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_THROTTLE_LIMIT: prdata = {16'd0, throttle_limit};
      CFG_POLES_LOWEST:   prdata = {16'd0, poles_lowest};
      CFG_POLES_HIGHEST:  prdata = {16'd0, poles_highest};
      CFG_CLEAR_KEY:      prdata = {16'd0, clear_key};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Transaction state.
  // Only page registers 0 to 2 are ever visible on the result stream, and the
  // clear register never lands in that range, so the page is held as those
  // three registers. Since a transaction covers at most MAX_WORDS consecutive
  // indexes, each visible register is targeted at most once per transaction;
  // staging is therefore kept per target (a pending value and a pending flag)
  // rather than per word position, and commit is a plain copy.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] word_position;
  logic [7:0]    latched_offset;
  status_t       first_error;

  logic [15:0]   arm_reg, throttle_reg, poles_reg;
  logic [15:0]   arm_stage, throttle_stage, poles_stage;
  logic          arm_pend, throttle_pend, poles_pend, clear_pend;

  logic          s_accept;
  logic [7:0]    in_offset;
  logic [15:0]   in_value;

  assign in_offset = s_tdata[7:0];
  assign in_value  = s_tdata[23:8];
  assign s_accept  = s_tvalid && s_tready;

  // Per-word checks, all against the current word and open transaction.
  logic [7:0]    offset_eff;
  logic [7:0]    target;
  logic          in_range;
  logic          hit_arm, hit_throttle, hit_poles, hit_clear;
  logic          pole_count_good;
  status_t       word_err;
  status_t       first_error_next;
  logic [PW-1:0] word_position_next;

  always_comb begin
    offset_eff = (word_position == '0) ? in_offset : latched_offset;
    target     = offset_eff + 8'(word_position);
    in_range   = (word_position != POS_FULL);

    hit_arm      = in_range && (target == REG_ARM);
    hit_throttle = in_range && (target == REG_THROTTLE);
    hit_poles    = in_range && (target == REG_POLES);
    hit_clear    = in_range && (target == CLEAR_INDEX);

    // A pole count of zero is always taken; otherwise it must be even and in range.
    pole_count_good = (in_value == 16'd0) ||
                      ((in_value >= poles_lowest) && (in_value <= poles_highest) &&
                       !in_value[0]);

    word_err = ST_OK;
    if (hit_throttle && (in_value > throttle_limit)) begin
      word_err = ST_BAD_VALUE;
    end else if (hit_clear && (in_value != clear_key)) begin
      word_err = ST_BAD_VALUE;
    end else if (hit_arm && (in_value != 16'd0) && !s_tuser) begin
      word_err = ST_NOT_ARMED;
    end else if (hit_poles && !pole_count_good) begin
      word_err = ST_BAD_VALUE;
    end

    // Words past the staging depth are not checked and fail as bad value.
    if (first_error != ST_OK) begin
      first_error_next = first_error;
    end else if (!in_range) begin
      first_error_next = ST_BAD_VALUE;
    end else begin
      first_error_next = word_err;
    end

    word_position_next = in_range ? word_position + PW'(1) : word_position;
  end

  // Result of a transaction that ends with the current word.
  logic    commit;
  result_t res_next;

  always_comb begin
    commit                = (first_error_next == ST_OK);
    res_next.status       = first_error_next;
    res_next.cleared      = commit && (clear_pend || hit_clear);
    res_next.arm_now      = arm_reg;
    res_next.throttle_now = throttle_reg;
    res_next.poles_now    = poles_reg;
    if (commit) begin
      if (hit_arm) begin
        res_next.arm_now = in_value;
      end else if (arm_pend) begin
        res_next.arm_now = arm_stage;
      end
      if (hit_throttle) begin
        res_next.throttle_now = in_value;
      end else if (throttle_pend) begin
        res_next.throttle_now = throttle_stage;
      end
      if (hit_poles) begin
        res_next.poles_now = in_value;
      end else if (poles_pend) begin
        res_next.poles_now = poles_stage;
      end
    end
  end

  // Control state: position, first error, pending flags and the page itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position  <= '0;
      latched_offset <= 8'd0;
      first_error    <= ST_OK;
      arm_pend       <= 1'b0;
      throttle_pend  <= 1'b0;
      poles_pend     <= 1'b0;
      clear_pend     <= 1'b0;
      arm_reg        <= 16'd0;
      throttle_reg   <= 16'd0;
      poles_reg      <= 16'd0;
    end else if (s_accept) begin
      if (s_tlast) begin
        // The transaction closes here; the page takes the committed contents.
        word_position  <= '0;
        first_error    <= ST_OK;
        arm_pend       <= 1'b0;
        throttle_pend  <= 1'b0;
        poles_pend     <= 1'b0;
        clear_pend     <= 1'b0;
        arm_reg        <= res_next.arm_now;
        throttle_reg   <= res_next.throttle_now;
        poles_reg      <= res_next.poles_now;
      end else begin
        word_position  <= word_position_next;
        latched_offset <= offset_eff;
        first_error    <= first_error_next;
        arm_pend       <= arm_pend || hit_arm;
        throttle_pend  <= throttle_pend || hit_throttle;
        poles_pend     <= poles_pend || hit_poles;
        clear_pend     <= clear_pend || hit_clear;
      end
    end
  end

  // Staged values; meaningful only while their pending flag is set.
  always_ff @(posedge clk) begin
    if (s_accept && !s_tlast) begin
      if (hit_arm) begin
        arm_stage <= in_value;
      end
      if (hit_throttle) begin
        throttle_stage <= in_value;
      end
      if (hit_poles) begin
        poles_stage <= in_value;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry. s_tready depends only on the skid entry,
  // so no combinational path runs from m_tready back to s_tready.
  // ---------------------------------------------------------------------------
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    push, out_free;

  assign s_tready = !skid_valid;
  assign push     = s_accept && s_tlast;
  assign out_free = m_tready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res_next;
      end
    end else if (push) begin
      skid_data <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data};

endmodule

`default_nettype wire

// File: bench/tb_control_page_write_validator.sv
`timescale 1ns / 1ps

module tb_control_page_write_validator;
  import cpwv_pkg::*;

  // Page geometry of the instance under test (default parameters).
  localparam int PAGE_REGS = 8;
  localparam int MAX_WORDS = 4;
  // Cycles to let pass after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 6;
  // Random words per register setting; five settings give about 1550 words.
  localparam int WORDS_PER_SETTING = 310;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // start_offset [7:0], word_value [23:8]
  logic        s_tlast;    // last_word
  logic        s_tuser;    // arm_allowed
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;    // status [1:0], cleared [2], arm_now [18:3],
                           // throttle_now [34:19], poles_now [50:35], zero fill
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  control_page_write_validator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Free running clock, 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Safety net: even the slowest legal run finishes far sooner than this.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Page model. It mirrors the configuration registers, the page contents and
  // the page write that is still open, and it is advanced once for every word
  // the block accepts.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_throttle;
  logic [15:0] cfg_poles_lo;
  logic [15:0] cfg_poles_hi;
  logic [15:0] cfg_key;

  logic [15:0] page_img [PAGE_REGS];
  logic [15:0] staged_img [MAX_WORDS];
  int          word_pos;
  logic [7:0]  open_offset;
  status_t     open_err;

  // Results still owed by the block, oldest first.
  result_t     owed_results[$];

  int n_fail;
  int n_words;
  int n_writes;
  int n_settings;
  int n_ok;
  int n_bad;
  int n_not_armed;
  int n_cleared;

  // Rule check for a single word aimed at register tgt.
  function automatic status_t word_status(logic [7:0] tgt, logic [15:0] v, logic arm);
    if (tgt == REG_THROTTLE && v > cfg_throttle) return ST_BAD_VALUE;
    if (tgt == CLEAR_INDEX && v != cfg_key) return ST_BAD_VALUE;
    if (tgt == REG_ARM && v != 16'd0 && !arm) return ST_NOT_ARMED;
    if (tgt == REG_POLES && v != 16'd0 &&
        !(v >= cfg_poles_lo && v <= cfg_poles_hi && !v[0])) return ST_BAD_VALUE;
    return ST_OK;
  endfunction

  // Advances the page model by one accepted word. A last word closes the page
  // write and yields the result that the block has to send.
  task automatic page_model_word(input logic [7:0] off_in, input logic [15:0] v,
                                 input logic last, input logic arm,
                                 output bit has_result, output result_t res);
    logic [7:0] tgt;
    status_t    st;
    bit         clr;
    has_result = 1'b0;
    res = '0;
    if (word_pos == 0) open_offset = off_in;
    if (word_pos < MAX_WORDS) begin
      tgt = open_offset + 8'(word_pos);
      st = word_status(tgt, v, arm);
      if (open_err == ST_OK) open_err = st;
      staged_img[word_pos] = v;
      word_pos++;
    end else if (open_err == ST_OK) begin
      // A word past the staging depth is never checked, only flagged.
      open_err = ST_BAD_VALUE;
    end
    if (last) begin
      clr = 1'b0;
      if (open_err == ST_OK) begin
        for (int k = 0; k < word_pos; k++) begin
          tgt = open_offset + 8'(k);
          if (tgt == CLEAR_INDEX) clr = 1'b1;
          else if (tgt < PAGE_REGS) page_img[tgt] = staged_img[k];
        end
      end
      res.status       = open_err;
      res.cleared      = clr;
      res.arm_now      = page_img[REG_ARM];
      res.throttle_now = page_img[REG_THROTTLE];
      res.poles_now    = page_img[REG_POLES];
      has_result = 1'b1;
      word_pos = 0;
      open_err = ST_OK;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. Every result transaction is compared field by field with
  // the oldest result still owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[50:0]);
      if (owed_results.size() == 0) begin
        $error("unexpected result transaction: m_tdata = %h", m_tdata);
        n_fail++;
      end else begin
        want = owed_results.pop_front();
        if (got.status != want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          n_fail++;
        end
        if (got.cleared != want.cleared) begin
          $error("cleared mismatch: expected %0d, got %0d", want.cleared, got.cleared);
          n_fail++;
        end
        if (got.arm_now != want.arm_now) begin
          $error("arm_now mismatch: expected %h, got %h", want.arm_now, got.arm_now);
          n_fail++;
        end
        if (got.throttle_now != want.throttle_now) begin
          $error("throttle_now mismatch: expected %h, got %h",
                 want.throttle_now, got.throttle_now);
          n_fail++;
        end
        if (got.poles_now != want.poles_now) begin
          $error("poles_now mismatch: expected %h, got %h", want.poles_now, got.poles_now);
          n_fail++;
        end
        case (want.status)
          ST_OK:        n_ok++;
          ST_BAD_VALUE: n_bad++;
          default:      n_not_armed++;
        endcase
        if (want.cleared) n_cleared++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure. Long stretches with m_tready held high alternate
  // with short random stalls and the occasional long stall, all changed at the
  // falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        @(negedge clk) m_tready <= 1'b1;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else if (r < 92) begin
        @(negedge clk) m_tready <= 1'b1;
        repeat ($urandom_range(0, 3)) @(posedge clk);
        @(negedge clk) m_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        @(negedge clk) m_tready <= 1'b0;
        repeat ($urandom_range(15, 50)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word side driving.
  // ---------------------------------------------------------------------------
  int quiet_left;

  // Gap after a word: mostly none, sometimes a few cycles, rarely a long one,
  // with stretches that have no gaps at all.
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one word and waits for its handshake. A typed result, where
  // given, replaces the model's in the owed list; the model still advances.
  task automatic send_word(input logic [7:0] off, input logic [15:0] v, input logic last,
                           input logic arm, input bit typed, input result_t typed_res);
    bit      has_result;
    result_t res;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {v, off};
    s_tlast  <= last;
    s_tuser  <= arm;
    do @(posedge clk); while (!s_tready);
    page_model_word(off, v, last, arm, has_result, res);
    if (has_result) begin
      owed_results.push_back(typed ? typed_res : res);
      n_writes++;
    end
    n_words++;
  endtask

  task automatic sender_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      repeat (g - 1) @(posedge clk);
    end
  endtask

  // Holds the word side idle until every owed result has arrived and the
  // block has had time to settle.
  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write over the configuration port: a setup phase, an access
  // phase, then the port goes idle again.
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, v};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      CFG_THROTTLE_LIMIT: cfg_throttle = v;
      CFG_POLES_LOWEST:   cfg_poles_lo = v;
      CFG_POLES_HIGHEST:  cfg_poles_hi = v;
      default:            cfg_key      = v;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [15:0] key);
    cfg_write(CFG_THROTTLE_LIMIT, thr);
    cfg_write(CFG_POLES_LOWEST, lo);
    cfg_write(CFG_POLES_HIGHEST, hi);
    cfg_write(CFG_CLEAR_KEY, key);
    n_settings++;
  endtask

  // A value for register tgt that passes its rule most of the time, with the
  // rule boundaries hit now and then.
  function automatic logic [15:0] pick_value(logic [7:0] tgt);
    int r;
    int lo;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'($urandom);
    if (tgt == REG_ARM) begin
      return (r < 55) ? 16'd0 : 16'($urandom);
    end else if (tgt == REG_THROTTLE) begin
      if (r < 30) return cfg_throttle + 16'($urandom_range(0, 1));
      return 16'($urandom_range(0, int'(cfg_throttle)));
    end else if (tgt == REG_POLES) begin
      if (r < 35) return 16'd0;
      if (r < 45) return cfg_poles_lo + 16'($urandom_range(0, 1));
      lo = int'(cfg_poles_lo) + int'(cfg_poles_lo[0]);
      if (lo > int'(cfg_poles_hi)) return 16'($urandom_range(0, 64));
      return 16'(lo + 2 * $urandom_range(0, (int'(cfg_poles_hi) - lo) / 2));
    end else if (tgt == CLEAR_INDEX) begin
      return (r < 85) ? cfg_key : cfg_key ^ 16'(1 << $urandom_range(0, 15));
    end
    return 16'($urandom);
  endfunction

  // One whole page write with random content. Most start on or near the
  // page; some are long enough to overflow the staging buffer, and some are
  // plain noise with random offset and values.
  task automatic random_page_write();
    int         len;
    int         r;
    bit         noise;
    logic [7:0] off;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    noise = (r >= 90);
    len = (r < 80 || noise) ? $urandom_range(1, MAX_WORDS) : $urandom_range(MAX_WORDS + 1, 7);
    if (noise || $urandom_range(0, 3) == 0) off = 8'($urandom);
    else off = 8'($urandom_range(0, 11) - 4);
    for (int k = 0; k < len; k++) begin
      v = noise ? 16'($urandom) : pick_value(off + 8'(k));
      // Only the first word carries a meaningful offset; later ones carry junk.
      send_word((k == 0) ? off : 8'($urandom), v, (k == len - 1), 1'($urandom),
                1'b0, '0);
      sender_gap();
    end
  endtask

  typedef struct {
    logic [7:0]  off;
    logic [15:0] val;
    logic        last;
    logic        arm;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic result_t mk_res(status_t st, bit clr, logic [15:0] a,
                                     logic [15:0] thr, logic [15:0] p);
    result_t res;
    res.status = st;
    res.cleared = clr;
    res.arm_now = a;
    res.throttle_now = thr;
    res.poles_now = p;
    return res;
  endfunction

  task automatic add_row(input logic [7:0] off, input logic [15:0] v, input logic last,
                         input logic arm, input bit typed, input result_t want);
    stim_row_t row;
    row = '{off, v, last, arm, typed, want};
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] lo;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_fail = 0;
    n_words = 0;
    n_writes = 0;
    n_settings = 1;
    n_ok = 0;
    n_bad = 0;
    n_not_armed = 0;
    n_cleared = 0;
    quiet_left = 0;
    cfg_throttle = THROTTLE_LIMIT_RST;
    cfg_poles_lo = POLES_LOWEST_RST;
    cfg_poles_hi = POLES_HIGHEST_RST;
    cfg_key = CLEAR_KEY_RST;
    foreach (page_img[i]) page_img[i] = '0;
    foreach (staged_img[i]) staged_img[i] = '0;
    word_pos = 0;
    open_offset = '0;
    open_err = ST_OK;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part, run with the reset configuration. Single word writes
    // carry their result typed in; multi-word rows go through the model.
    add_row(8'd0, 16'h0000, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b0, 16'h0000, 16'd0, 16'd0));
    add_row(8'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1,
            mk_res(ST_NOT_ARMED, 1'b0, 16'h0000, 16'd0, 16'd0));
    add_row(8'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1,
            mk_res(ST_OK, 1'b0, 16'hFFFF, 16'd0, 16'd0));
    add_row(8'd1, 16'd1000, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b0, 16'hFFFF, 16'd1000, 16'd0));
    add_row(8'd1, 16'd1001, 1'b1, 1'b0, 1'b1,
            mk_res(ST_BAD_VALUE, 1'b0, 16'hFFFF, 16'd1000, 16'd0));
    add_row(8'd2, 16'd36, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b0, 16'hFFFF, 16'd1000, 16'd36));
    add_row(8'd2, 16'd38, 1'b1, 1'b0, 1'b1,
            mk_res(ST_BAD_VALUE, 1'b0, 16'hFFFF, 16'd1000, 16'd36));
    add_row(8'd2, 16'd3, 1'b1, 1'b0, 1'b1,
            mk_res(ST_BAD_VALUE, 1'b0, 16'hFFFF, 16'd1000, 16'd36));
    add_row(8'd2, 16'd0, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b0, 16'hFFFF, 16'd1000, 16'd0));
    add_row(8'd2, 16'd2, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b0, 16'hFFFF, 16'd1000, 16'd2));
    add_row(8'd3, 16'hA5A5, 1'b1, 1'b0, 1'b1,
            mk_res(ST_OK, 1'b1, 16'hFFFF, 16'd1000, 16'd2));
    add_row(8'd3, 16'hA5A4, 1'b1, 1'b0, 1'b1,
            mk_res(ST_BAD_VALUE, 1'b0, 16'hFFFF, 16'd1000, 16'd2));
    // Offset wrap from the top index into the page; later offsets are ignored.
    add_row(8'hFF, 16'h1234, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'hAA, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h55, 16'd500, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 16'd4, 1'b1, 1'b1, 1'b0, '0);
    // One word more than the staging buffer holds.
    add_row(8'd4, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'd0, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'd0, 16'h0001, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'd0, 16'h8000, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'd0, 16'h0007, 1'b1, 1'b0, 1'b0, '0);
    // Runs past the end of the page.
    add_row(8'd6, 16'h00FF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'd0, 16'hFF00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, '0);
    // Two failing words: the earlier failure decides the status.
    add_row(8'd0, 16'h0001, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h11, 16'd2000, 1'b1, 1'b1, 1'b0, '0);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].off, dir_rows[i].val, dir_rows[i].last, dir_rows[i].arm,
                dir_rows[i].typed, dir_rows[i].want);
      sender_gap();
    end
    drain();

    // Random part over five register settings: both extremes first (the
    // first one leaves an empty range of pole counts), then random settings.
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: set_config(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        1: set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        2: set_config(16'($urandom), 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 40)), 16'($urandom));
        default: begin
          lo = 16'($urandom_range(0, 12));
          set_config(16'($urandom), lo, lo + 16'($urandom_range(0, 40)), 16'($urandom));
        end
      endcase
      while (n_words < 26 + (s + 1) * WORDS_PER_SETTING) begin
        random_page_write();
        // Now and then the sender waits for every owed result.
        if ($urandom_range(0, 99) < 3) drain();
      end
      drain();
    end

    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      n_fail++;
    end
    $display("Sent %0d words in %0d page writes under %0d register settings.",
             n_words, n_writes, n_settings);
    $display("Outcomes: %0d accepted, %0d bad value, %0d not armed, %0d clears.",
             n_ok, n_bad, n_not_armed, n_cleared);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
